/* hdl/npcs_pkg.sv */
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared constants and types for the nearest palette color search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W           = $clog2(PALETTE_ENTRIES);

	localparam int CHAN_W   = 8;
	localparam int FIELD_W  = 5;
	localparam int COLOR_W  = 15;
	localparam int SQ_W     = 2 * CHAN_W;
	localparam int DIST_W   = 18;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// tag that travels with each palette read through the scan pipeline
	typedef struct packed {
		logic             vld;
		logic             last;
		logic [IDX_W-1:0] idx;
	} scan_tag_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

endpackage

/* hdl/npcs_cmd_if.sv */
// ----------------------------------------------------------------------------
// npcs_cmd_if
// Input channel: palette writes and color queries.
// ----------------------------------------------------------------------------
interface npcs_cmd_if;
	import npcs_pkg::*;

	logic                valid;
	logic                ready;
	logic                func;
	logic [7:0]          entry_index;
	logic [CHAN_W-1:0]   red;
	logic [CHAN_W-1:0]   green;
	logic [CHAN_W-1:0]   blue;
	logic [COLOR_W-1:0]  color15;

	modport source (
		output valid, func, entry_index, red, green, blue, color15,
		input  ready
	);

	modport sink (
		input  valid, func, entry_index, red, green, blue, color15,
		output ready
	);

endinterface

/* hdl/npcs_result_if.sv */
// ----------------------------------------------------------------------------
// npcs_result_if
// Output channel: nearest palette index and its squared distance.
// ----------------------------------------------------------------------------
interface npcs_result_if;
	import npcs_pkg::*;

	logic              valid;
	logic              ready;
	logic [7:0]        nearest_index;
	logic [DIST_W-1:0] nearest_distance_sq;

	modport source (
		output valid, nearest_index, nearest_distance_sq,
		input  ready
	);

	modport sink (
		input  valid, nearest_index, nearest_distance_sq,
		output ready
	);

endinterface

/* hdl/npcs_palette_ram.sv */
// ----------------------------------------------------------------------------
// npcs_palette_ram
// Palette store: one write port, one registered read port. Per-entry valid
// flags cleared by reset make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module npcs_palette_ram (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [npcs_pkg::IDX_W-1:0] wr_addr,
	input  npcs_pkg::rgb_t            wr_data,
	input  npcs_pkg::scan_tag_t       rd_tag,
	output npcs_pkg::scan_tag_t       tag_s1,
	output npcs_pkg::rgb_t            entry_s1
);
	import npcs_pkg::*;

	rgb_t                       mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] written_q;
	rgb_t                       data_s1;
	logic                       written_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		data_s1 <= mem[rd_tag.idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			written_s1 <= 1'b0;
			tag_s1     <= '0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			written_s1 <= written_q[rd_tag.idx];
			tag_s1     <= rd_tag;
		end
	end

	assign entry_s1 = written_s1 ? data_s1 : '0;

endmodule

/* hdl/npcs_dist_unit.sv */
// ----------------------------------------------------------------------------
// npcs_dist_unit
// Shared distance unit: per-channel squared differences, registered, then
// summed into the squared RGB distance of one palette entry per cycle.
// ----------------------------------------------------------------------------
module npcs_dist_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  npcs_pkg::rgb_t              query,
	input  npcs_pkg::scan_tag_t         tag_s1,
	input  npcs_pkg::rgb_t              entry_s1,
	output npcs_pkg::scan_tag_t         tag_s2,
	output logic [npcs_pkg::DIST_W-1:0] dist_s2
);
	import npcs_pkg::*;

	logic [CHAN_W-1:0] diff_r, diff_g, diff_b;
	logic [SQ_W-1:0]   sq_r_s2, sq_g_s2, sq_b_s2;

	always_comb begin
		diff_r = (query.red   >= entry_s1.red)   ? query.red   - entry_s1.red
		                                         : entry_s1.red   - query.red;
		diff_g = (query.green >= entry_s1.green) ? query.green - entry_s1.green
		                                         : entry_s1.green - query.green;
		diff_b = (query.blue  >= entry_s1.blue)  ? query.blue  - entry_s1.blue
		                                         : entry_s1.blue  - query.blue;
	end

	always_ff @(posedge clk) begin
		sq_r_s2 <= SQ_W'(diff_r) * SQ_W'(diff_r);
		sq_g_s2 <= SQ_W'(diff_g) * SQ_W'(diff_g);
		sq_b_s2 <= SQ_W'(diff_b) * SQ_W'(diff_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	assign dist_s2 = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

endmodule

/* hdl/nearest_palette_color_search.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Nearest-color lookup of an RGB555 color against a 256-entry RGB palette.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per handshake. func = write stores red/green/blue
//   at entry_index (indexes past the palette are dropped) and gives no
//   result. func = query expands each 5-bit field of
//   color15 to (field << 3) + 4 and scans the palette.
//   result carries, per query, the lowest index at minimum squared RGB
//   distance and that distance.
//   A query scans the whole palette: the single read port of the palette
//   RAM feeds one entry per cycle into the distance unit, followed by the
//   RAM read, square and select stages.
//   cmd.ready is low for the whole scan and until the result is loaded
//   into the output register; no new item is taken before then.
//   A finished result sits in an output register; the next item is taken
//   while it waits. If result is stalled when a second scan finishes, that
//   scan holds its result and cmd stays low until the register frees.
//   Reset clears the palette to all zeros (per-entry flags) and empties
//   the output.
// ----------------------------------------------------------------------------
module nearest_palette_color_search (
	input  logic          clk,
	input  logic          arst_n,
	npcs_cmd_if.sink      cmd,
	npcs_result_if.source result
);
	import npcs_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam int               EXT_W    = IDX_W + 8;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

	logic [1:0]        state_q;
	logic [IDX_W-1:0]  cnt_q;
	rgb_t              query_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [DIST_W-1:0] best_dist_q;
	logic              out_valid_q;
	logic [7:0]        out_idx_q;
	logic [DIST_W-1:0] out_dist_q;

	logic              accept;
	logic [EXT_W-1:0]  wr_ext;
	logic              wr_en;
	rgb_t              wr_data;
	scan_tag_t         rd_tag;
	scan_tag_t         tag_s1;
	scan_tag_t         tag_s2;
	rgb_t              entry_s1;
	logic [DIST_W-1:0] dist_s2;
	logic              take_best;
	logic              out_load;
	logic [EXT_W-1:0]  best_ext;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	assign wr_ext  = EXT_W'(cmd.entry_index);
	assign wr_en   = accept && (cmd.func == FUNC_WRITE)
	                 && (wr_ext < EXT_W'(PALETTE_ENTRIES));
	assign wr_data = '{blue: cmd.blue, green: cmd.green, red: cmd.red};

	always_comb begin
		rd_tag      = '0;
		rd_tag.vld  = (state_q == ST_SCAN);
		rd_tag.last = (cnt_q == LAST_IDX);
		rd_tag.idx  = cnt_q;
	end

	npcs_palette_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_ext[IDX_W-1:0]),
		.wr_data  (wr_data),
		.rd_tag   (rd_tag),
		.tag_s1   (tag_s1),
		.entry_s1 (entry_s1)
	);

	npcs_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.query    (query_q),
		.tag_s1   (tag_s1),
		.entry_s1 (entry_s1),
		.tag_s2   (tag_s2),
		.dist_s2  (dist_s2)
	);

	// entry 0 always seeds the best; later entries only win on strictly less
	assign take_best = tag_s2.vld && ((tag_s2.idx == '0) || (dist_s2 < best_dist_q));
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || result.ready);
	assign best_ext  = EXT_W'(best_idx_q);

	always_ff @(posedge clk) begin
		if (accept && (cmd.func == FUNC_QUERY)) begin
			query_q.red   <= {cmd.color15[FIELD_W-1:0], 3'b100};
			query_q.green <= {cmd.color15[2*FIELD_W-1:FIELD_W], 3'b100};
			query_q.blue  <= {cmd.color15[3*FIELD_W-1:2*FIELD_W], 3'b100};
		end
		if (take_best) begin
			best_idx_q  <= tag_s2.idx;
			best_dist_q <= dist_s2;
		end
		if (out_load) begin
			out_idx_q  <= best_ext[7:0];
			out_dist_q <= best_dist_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd.func == FUNC_QUERY)) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (tag_s2.vld && tag_s2.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid               = out_valid_q;
	assign result.nearest_index       = out_idx_q;
	assign result.nearest_distance_sq = out_dist_q;

endmodule
